// ===== rtl/pcrx_pkg.sv =====
// ----------------------------------------------------------------------------
// pcrx_pkg
// Shared types and constants for the measurement register extend block.
// ----------------------------------------------------------------------------
package pcrx_pkg;

    localparam int DIGEST_W = 160;
    localparam int MEAS_W   = 160;
    localparam int INDEX_W  = 8;

    localparam logic KIND_READ   = 1'b0;
    localparam logic KIND_EXTEND = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    // classified request handed from front to back
    typedef struct packed {
        logic                   extend;
        logic                   bad_index;
        logic [INDEX_W-1:0]     index;
        logic [MEAS_W-1:0]      meas;
    } pcrx_req_t;

    // sha-1 initial value
    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;

    function automatic logic [31:0] round_k(input logic [6:0] rnd);
        logic [31:0] k;
        begin
            if (rnd < 7'd20)      k = 32'h5A827999;
            else if (rnd < 7'd40) k = 32'h6ED9EBA1;
            else if (rnd < 7'd60) k = 32'h8F1BBCDC;
            else                  k = 32'hCA62C1D6;
            return k;
        end
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] rnd,
                                            input logic [31:0] b,
                                            input logic [31:0] c,
                                            input logic [31:0] d);
        logic [31:0] f;
        begin
            if (rnd < 7'd20)      f = (b & c) | (~b & d);
            else if (rnd < 7'd40) f = b ^ c ^ d;
            else if (rnd < 7'd60) f = (b & c) | (b & d) | (c & d);
            else                  f = b ^ c ^ d;
            return f;
        end
    endfunction

endpackage

// ===== rtl/pcrx_front.sv =====
// ----------------------------------------------------------------------------
// pcrx_front
// Accepts requests, checks the index and queues them for the back end.
// ----------------------------------------------------------------------------
module pcrx_front #(
    parameter int REG_COUNT = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  s_kind,
    input  logic [7:0]            s_index,
    input  logic [159:0]          s_meas,
    output logic                  req_valid,
    input  logic                  req_ready,
    output pcrx_pkg::pcrx_req_t   req
);
    import pcrx_pkg::*;

    // two-entry queue
    pcrx_req_t q_reg [2];
    logic      rd_ptr_reg, rd_ptr_next;
    logic      wr_ptr_reg, wr_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic      push, pop;
    pcrx_req_t in_req;

    // classify incoming word
    always_comb begin
        in_req.extend    = (s_kind == KIND_EXTEND);
        in_req.bad_index = ({24'd0, s_index} >= 32'(REG_COUNT));
        in_req.index     = s_index;
        in_req.meas      = s_meas;
    end

    assign s_tready  = (cnt_reg != 2'd2);
    assign push      = s_tvalid && s_tready;
    assign req_valid = (cnt_reg != 2'd0);
    assign pop       = req_valid && req_ready;
    assign req       = q_reg[rd_ptr_reg];

    // pointer update
    always_comb begin
        rd_ptr_next = rd_ptr_reg ^ pop;
        wr_ptr_next = wr_ptr_reg ^ push;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_req;
        end
    end

endmodule

// ===== rtl/pcrx_back.sv =====
// ----------------------------------------------------------------------------
// pcrx_back
// Executes reads and extends: register bank, sha-1 round engine, output.
// ----------------------------------------------------------------------------
module pcrx_back #(
    parameter int REG_COUNT = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  pcrx_pkg::pcrx_req_t   req,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [167:0]          m_tdata    // status, value_high, value_mid, value_low, pad
);
    import pcrx_pkg::*;

    localparam int IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    typedef enum logic [1:0] {ST_IDLE, ST_ROUND, ST_OUT} state_t;

    state_t          state_reg;
    logic [159:0]    bank_reg [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;
    logic [31:0]     w_reg [16];
    logic [31:0]     a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [6:0]      rnd_reg;
    logic [IDX_W-1:0] idx_reg;
    logic            status_reg;
    logic [159:0]    value_reg;

    logic [IDX_W-1:0] rd_idx;
    logic [159:0]    old_val;
    logic [31:0]     w_new, t_val, wt;

    assign rd_idx  = req.index[IDX_W-1:0];
    assign old_val = valid_reg[rd_idx] ? bank_reg[rd_idx] : 160'd0;

    // schedule word and round value
    assign wt    = w_reg[0];
    assign w_new = {(w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0])}
                   <<< 0;
    assign t_val = {a_reg[26:0], a_reg[31:27]} + round_f(rnd_reg, b_reg, c_reg, d_reg)
                   + e_reg + round_k(rnd_reg) + wt;

    assign req_ready = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_OUT);
    assign m_tdata   = {7'd0, value_reg[31:0], value_reg[95:32], value_reg[159:96],
                        status_reg};

    // control and datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            rnd_reg   <= 7'd0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (req_valid) begin
                        idx_reg <= rd_idx;
                        if (req.bad_index) begin
                            status_reg <= STATUS_RANGE;
                            value_reg  <= 160'd0;
                            state_reg  <= ST_OUT;
                        end else if (!req.extend) begin
                            status_reg <= STATUS_OK;
                            value_reg  <= old_val;
                            state_reg  <= ST_OUT;
                        end else begin
                            status_reg <= STATUS_OK;
                            for (int i = 0; i < 5; i++) begin
                                w_reg[i] <= old_val[159-32*i -: 32];
                                w_reg[5+i] <= req.meas[159-32*i -: 32];
                            end
                            w_reg[10] <= 32'h80000000;
                            for (int i = 11; i < 15; i++) begin
                                w_reg[i] <= 32'd0;
                            end
                            w_reg[15] <= 32'd320;
                            a_reg <= H0; b_reg <= H1; c_reg <= H2;
                            d_reg <= H3; e_reg <= H4;
                            rnd_reg   <= 7'd0;
                            state_reg <= ST_ROUND;
                        end
                    end
                end
                ST_ROUND: begin
                    if (rnd_reg == 7'd80) begin
                        value_reg <= {H0 + a_reg, H1 + b_reg, H2 + c_reg,
                                      H3 + d_reg, H4 + e_reg};
                        bank_reg[idx_reg] <= {H0 + a_reg, H1 + b_reg, H2 + c_reg,
                                              H3 + d_reg, H4 + e_reg};
                        valid_reg[idx_reg] <= 1'b1;
                        state_reg <= ST_OUT;
                    end else begin
                        for (int i = 0; i < 15; i++) begin
                            w_reg[i] <= w_reg[i+1];
                        end
                        w_reg[15] <= {w_new[30:0], w_new[31]};
                        e_reg <= d_reg;
                        d_reg <= c_reg;
                        c_reg <= {b_reg[1:0], b_reg[31:2]};
                        b_reg <= a_reg;
                        a_reg <= t_val;
                        rnd_reg <= rnd_reg + 7'd1;
                    end
                end
                ST_OUT: begin
                    if (m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/pcr_bank_sha1_extend_unit.sv =====
// ----------------------------------------------------------------------------
// pcr_bank_sha1_extend_unit
// Bank of 160-bit measurement registers with sha-1 extend and read.
// ----------------------------------------------------------------------------
// Requests enter on the s_ stream: tuser carries the kind (0 read,
// 1 extend), tdata the register index and the 20-byte measurement.
// Every request returns one word on the m_ stream with a status bit and
// the register value after the operation (zero when the index is out of
// range). A front end checks the index and holds up to two requests in a
// queue; the back end runs one request at a time.
// After it is accepted, an extend passes through the queue, a load step,
// 80 sha-1 rounds done one per cycle by a single round unit and a finish
// step before it can complete its output handshake. A read or a bad
// index passes through the queue and a load step straight to the output.
// The back end loads its next request the cycle after the output
// handshake, so it takes no new request before the last result is taken.
// Reset clears all registers to zero at once. If the receiver stalls the
// result holds in the output register; the queue keeps taking requests
// until it is full, then s_tready drops.
// ----------------------------------------------------------------------------
module pcr_bank_sha1_extend_unit #(
    parameter int REG_COUNT = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [167:0] s_tdata,   // reg_index, meas_high, meas_mid, meas_low
    input  logic         s_tuser,   // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [167:0] m_tdata    // status, value_high, value_mid, value_low, pad
);
    import pcrx_pkg::*;

    pcrx_req_t req;
    logic      req_valid, req_ready;

    // front end
    pcrx_front #(.REG_COUNT(REG_COUNT)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_kind    (s_tuser),
        .s_index   (s_tdata[7:0]),
        .s_meas    ({s_tdata[71:8], s_tdata[135:72], s_tdata[167:136]}),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req)
    );

    // back end
    pcrx_back #(.REG_COUNT(REG_COUNT)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the measurement register bank: reads and sha-1 extends against a
// local predictor of the bank, with random idling on both stream sides.
// ----------------------------------------------------------------------------
module tb_top;
    import pcrx_pkg::*;

    localparam int NREG = 8;

    typedef struct {
        logic         status;
        logic [63:0]  vh;
        logic [63:0]  vm;
        logic [31:0]  vl;
    } bank_word_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [167:0] s_tdata;   // reg_index, meas_high, meas_mid, meas_low
    logic         s_tuser;   // kind
    logic         m_tvalid;
    logic         m_tready;
    logic [167:0] m_tdata;   // status, value_high, value_mid, value_low, pad

    logic [159:0] bank_model [NREG];
    bank_word_t   expected_words [$];
    int           n_errors;
    int           n_checked;
    int           n_extends;
    int           n_reads;
    int           n_bad;
    bit           stall_on;

    pcr_bank_sha1_extend_unit #(.REG_COUNT(NREG)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic [31:0] rol(logic [31:0] x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // sha-1 of old register value followed by 20-byte measurement
    function automatic logic [159:0] extend_digest(logic [159:0] old, logic [159:0] meas);
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        logic [511:0] blk;
        blk = {old, meas, 32'h80000000, 128'd0, 32'd320};
        for (int i = 0; i < 16; i++) w[i] = blk[511 - 32*i -: 32];
        for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = 32'h67452301; b = 32'hEFCDAB89; c = 32'h98BADCFE;
        d = 32'h10325476; e = 32'hC3D2E1F0;
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d); k = 32'h5A827999;
            end else if (i < 40) begin
                f = b ^ c ^ d; k = 32'h6ED9EBA1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d; k = 32'hCA62C1D6;
            end
            t = rol(a, 5) + f + e + k + w[i];
            e = d; d = c; c = rol(b, 30); b = a; a = t;
        end
        return {a + 32'h67452301, b + 32'hEFCDAB89, c + 32'h98BADCFE,
                d + 32'h10325476, e + 32'hC3D2E1F0};
    endfunction

    // apply one request to the bank model and queue its result
    task automatic predict_bank(logic kind, logic [7:0] idx, logic [159:0] meas);
        bank_word_t r;
        if (idx >= NREG) begin
            r.status = STATUS_RANGE; r.vh = '0; r.vm = '0; r.vl = '0;
            n_bad++;
        end else begin
            if (kind == KIND_EXTEND) begin
                bank_model[idx] = extend_digest(bank_model[idx], meas);
                n_extends++;
            end else begin
                n_reads++;
            end
            r.status = STATUS_OK;
            {r.vh, r.vm, r.vl} = bank_model[idx];
        end
        expected_words.push_back(r);
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        n_errors++;
    endtask

    // send one word, with an optional random gap before it
    task automatic send_word(logic kind, logic [7:0] idx, logic [159:0] meas, bit gaps);
        if (gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {meas[31:0], meas[95:32], meas[159:96], idx};
        do @(posedge aclk); while (!s_tready);
        predict_bank(kind, idx, meas);
    endtask

    function automatic logic [159:0] rand_meas();
        return {$urandom, $urandom, $urandom, $urandom, $urandom};
    endfunction

    // receiver stalls
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (stall_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    // result checker
    initial begin
        bank_word_t want;
        logic [63:0] gh, gm;
        logic [31:0] gl;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                gh = m_tdata[64:1];
                gm = m_tdata[128:65];
                gl = m_tdata[160:129];
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word", 64'(m_tdata[0]), 64'd0);
                end else begin
                    want = expected_words.pop_front();
                    n_checked++;
                    if (m_tdata[0] !== want.status)
                        report_mismatch("status", 64'(m_tdata[0]), 64'(want.status));
                    if (gh !== want.vh) report_mismatch("value_high", gh, want.vh);
                    if (gm !== want.vm) report_mismatch("value_mid", gm, want.vm);
                    if (gl !== want.vl) report_mismatch("value_low", 64'(gl), 64'(want.vl));
                end
            end
        end
    end

    task automatic test_directed();
        send_word(KIND_READ, 8'd0, '0, 0);
        send_word(KIND_READ, 8'(NREG - 1), '1, 0);
        send_word(KIND_EXTEND, 8'd0, '0, 0);
        send_word(KIND_EXTEND, 8'd0, '1, 0);
        send_word(KIND_READ, 8'd0, rand_meas(), 0);
        send_word(KIND_EXTEND, 8'(NREG - 1), '1, 0);
        send_word(KIND_EXTEND, 8'd3, {5{32'hA5A5A5A5}}, 0);
        send_word(KIND_EXTEND, 8'd4, {5{32'h5A5A5A5A}}, 0);
        send_word(KIND_READ, 8'(NREG), rand_meas(), 0);
        send_word(KIND_EXTEND, 8'(NREG), '1, 0);
        send_word(KIND_EXTEND, 8'd255, '1, 0);
        send_word(KIND_READ, 8'd255, '0, 0);
        send_word(KIND_READ, 8'd170, '0, 0);
        send_word(KIND_READ, 8'd85, '0, 0);
        send_word(KIND_READ, 8'd3, '0, 0);
        for (int r = 0; r < NREG; r++) send_word(KIND_READ, 8'(r), '0, 0);
    endtask

    // drain: sender holds off until every result is back
    task automatic test_drain_pause();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        send_word(KIND_EXTEND, 8'd1, rand_meas(), 0);
        send_word(KIND_READ, 8'd1, '0, 0);
    endtask

    task automatic test_random(int n, bit gaps);
        logic [7:0] idx;
        logic kind;
        for (int i = 0; i < n; i++) begin
            idx = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, NREG - 1));
            kind = ($urandom_range(0, 2) != 0) ? KIND_EXTEND : KIND_READ;
            send_word(kind, idx, rand_meas(), gaps);
        end
    endtask

    // limit
    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    initial begin
        n_errors = 0; n_checked = 0; n_extends = 0; n_reads = 0; n_bad = 0;
        stall_on = 1'b1;
        for (int r = 0; r < NREG; r++) bank_model[r] = '0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = 1'b0;
        s_tdata  = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_drain_pause();
        test_random(1300, 1);
        stall_on <= 1'b0;
        test_random(320, 0);
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("covered %0d extends, %0d reads, %0d out-of-range requests",
                 n_extends, n_reads, n_bad);
        $display("%0d result words checked, %0d mismatches", n_checked, n_errors);
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== pcr_bank_sha1_extend_unit.f =====
rtl/pcrx_pkg.sv
rtl/pcrx_front.sv
rtl/pcrx_back.sv
rtl/pcr_bank_sha1_extend_unit.sv
test/tb_top.sv
